>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL files. Each check is sampled on the
// rising edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true at a sampled edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

>>> sv/lcr_pkg.sv
package lcr_pkg;

  // Number of data bits shifted out of the converter per conversion.
  localparam int unsigned DATA_BITS  = 24;
  // Counter wide enough to hold DATA_BITS itself.
  localparam int unsigned IDX_W      = $clog2(DATA_BITS + 1);

  localparam int unsigned READ_W     = 24;
  localparam int unsigned NET_W      = READ_W + 1;
  localparam int unsigned GAIN_W     = 2;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned PROD_W     = READ_W + SCALE_W;
  localparam int unsigned WIDE_W     = 33;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic signed [READ_W-1:0] READ_MAX = 24'sh7F_FFFF;
  localparam logic signed [READ_W-1:0] READ_MIN = 24'sh80_0000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE  = 2'd2;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_TARE  = 3'd1,
    OP_LOAD  = 3'd2,
    OP_PDOWN = 3'd3,
    OP_START = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_DATA = 2'd1,
    PH_GAIN = 2'd2
  } phase_e;

  typedef struct packed {
    logic [GAIN_W-1:0]         gain_pulses;
    logic signed [READ_W-1:0]  offset_preset;
    logic [SCALE_W-1:0]        scale_recip;
  } cfg_t;

  // Result of the engine stage, before the magnitude is formed.
  typedef struct packed {
    logic                      clock_pin;
    logic                      sample_done;
    logic                      data_ready;
    logic signed [READ_W-1:0]  raw;
    logic signed [NET_W-1:0]   net;
  } s1_t;

  // Result after the magnitude stage.
  typedef struct packed {
    logic                      clock_pin;
    logic                      sample_done;
    logic                      data_ready;
    logic signed [READ_W-1:0]  raw;
    logic [READ_W-1:0]         mag;
  } s2_t;

  // Sign-extends the shifted word and clamps it to the 24-bit signed range.
  function automatic logic signed [READ_W-1:0] finish_word(input logic [DATA_BITS-1:0] w);
    logic signed [WIDE_W-1:0] v;
    v = WIDE_W'($signed(w));
    if (v > WIDE_W'(READ_MAX)) begin
      return READ_MAX;
    end else if (v < WIDE_W'(READ_MIN)) begin
      return READ_MIN;
    end
    return READ_W'(v);
  endfunction

endpackage

>>> sv/lcr_engine.sv
`include "assert_macros.svh"

module lcr_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lcr_pkg::cfg_t      cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic               data_pin_i,
  output logic               s1_valid_o,
  input  logic               s1_ready_i,
  output lcr_pkg::s1_t       s1_o
);

  lcr_pkg::phase_e                       ph_q, ph_d;
  logic [lcr_pkg::IDX_W-1:0]             idx_q, idx_d, idx_n;
  logic                                  ch_q, ch_d;
  logic                                  pd_q, pd_d;
  logic [lcr_pkg::DATA_BITS-1:0]         sh_q, sh_d;
  logic signed [lcr_pkg::READ_W-1:0]     lr_q, lr_d;
  logic signed [lcr_pkg::READ_W-1:0]     off_q, off_d;
  logic [lcr_pkg::GAIN_W-1:0]            gp;
  logic                                  clk_c, done_c, rdy_c;
  logic                                  v1_q;
  lcr_pkg::s1_t                          s1_q;
  logic                                  fire;

  assign in_ready_o = !v1_q || s1_ready_i;
  assign fire       = in_valid_i && in_ready_o;
  assign s1_valid_o = v1_q;
  assign s1_o       = s1_q;

  always_comb begin
    pd_d   = pd_q;
    ph_d   = ph_q;
    idx_d  = idx_q;
    ch_d   = ch_q;
    sh_d   = sh_q;
    lr_d   = lr_q;
    off_d  = off_q;
    clk_c  = 1'b0;
    done_c = 1'b0;
    rdy_c  = 1'b0;

    // The command acts first.
    case (lcr_pkg::op_e'(op_i))
      lcr_pkg::OP_TARE: begin
        off_d = lr_q;
      end
      lcr_pkg::OP_LOAD: begin
        off_d = cfg_i.offset_preset;
      end
      lcr_pkg::OP_PDOWN: begin
        pd_d  = 1'b1;
        ph_d  = lcr_pkg::PH_IDLE;
        idx_d = '0;
        ch_d  = 1'b0;
      end
      lcr_pkg::OP_START: begin
        pd_d  = 1'b0;
        ph_d  = lcr_pkg::PH_IDLE;
        idx_d = '0;
        ch_d  = 1'b0;
      end
      default: begin
      end
    endcase

    idx_n = idx_d + 1'b1;
    gp    = (cfg_i.gain_pulses == '0) ? lcr_pkg::GAIN_W'(1) : cfg_i.gain_pulses;

    // Then the serial engine runs on the same tick.
    if (pd_d) begin
      clk_c = 1'b1;
    end else begin
      case (ph_d)
        lcr_pkg::PH_DATA, lcr_pkg::PH_GAIN: begin
          if (!ch_d) begin
            clk_c = 1'b1;
            ch_d  = 1'b1;
          end else begin
            ch_d = 1'b0;
            if (ph_d == lcr_pkg::PH_DATA) begin
              sh_d = {sh_d[lcr_pkg::DATA_BITS-2:0], data_pin_i};
              if (idx_n >= lcr_pkg::IDX_W'(lcr_pkg::DATA_BITS)) begin
                ph_d  = lcr_pkg::PH_GAIN;
                idx_d = '0;
              end else begin
                idx_d = idx_n;
              end
            end else begin
              if (idx_n >= lcr_pkg::IDX_W'(gp)) begin
                lr_d   = lcr_pkg::finish_word(sh_d);
                done_c = 1'b1;
                ph_d   = lcr_pkg::PH_IDLE;
                idx_d  = '0;
              end else begin
                idx_d = idx_n;
              end
            end
          end
        end
        default: begin
          ph_d = lcr_pkg::PH_IDLE;
          if (!data_pin_i) begin
            rdy_c = 1'b1;
            ph_d  = lcr_pkg::PH_DATA;
            idx_d = '0;
            ch_d  = 1'b0;
            sh_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= lcr_pkg::PH_IDLE;
      idx_q <= '0;
      ch_q  <= 1'b0;
      pd_q  <= 1'b0;
      sh_q  <= '0;
      lr_q  <= '0;
      off_q <= '0;
    end else if (fire) begin
      ph_q  <= ph_d;
      idx_q <= idx_d;
      ch_q  <= ch_d;
      pd_q  <= pd_d;
      sh_q  <= sh_d;
      lr_q  <= lr_d;
      off_q <= off_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (in_ready_o) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      s1_q.clock_pin   <= clk_c;
      s1_q.sample_done <= done_c;
      s1_q.data_ready  <= rdy_c;
      s1_q.raw         <= lr_d;
      s1_q.net         <= lcr_pkg::NET_W'(lr_d) - lcr_pkg::NET_W'(off_d);
    end
  end

  `ASSERT_PROP(a_pd_idle, pd_q |-> (ph_q == lcr_pkg::PH_IDLE), "powered down while reading")
  `ASSERT_PROP(a_idle_clean, (ph_q == lcr_pkg::PH_IDLE) |-> (!ch_q && idx_q == '0), "idle with pulse state")
  `ASSERT_NEVER(a_idx_range, (ph_q == lcr_pkg::PH_DATA) && (idx_q >= lcr_pkg::IDX_W'(lcr_pkg::DATA_BITS)), "data bit count overrun")

endmodule

>>> sv/lcr_scale.sv
`include "assert_macros.svh"

module lcr_scale (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [lcr_pkg::SCALE_W-1:0]     scale_i,
  input  logic                            s1_valid_i,
  output logic                            s1_ready_o,
  input  lcr_pkg::s1_t                    s1_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            clock_pin_o,
  output logic                            sample_done_o,
  output logic signed [lcr_pkg::READ_W-1:0] raw_reading_o,
  output logic [lcr_pkg::READ_W-1:0]      net_magnitude_o,
  output logic [lcr_pkg::READ_W-1:0]      weight_o,
  output logic                            data_ready_o
);

  logic                          v2_q, v3_q;
  logic                          en3;
  lcr_pkg::s2_t                  s2_q;
  lcr_pkg::s2_t                  s3_q;
  logic [lcr_pkg::READ_W-1:0]    wt_q;
  logic [lcr_pkg::NET_W-1:0]     abs_c;
  logic [lcr_pkg::PROD_W-1:0]    prod_c;

  assign en3        = !v3_q || out_ready_i;
  assign s1_ready_o = !v2_q || en3;

  assign abs_c  = s1_i.net[lcr_pkg::NET_W-1] ? lcr_pkg::NET_W'(-s1_i.net)
                                             : lcr_pkg::NET_W'(s1_i.net);
  assign prod_c = lcr_pkg::PROD_W'(s2_q.mag) * lcr_pkg::PROD_W'(scale_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s1_ready_o) begin
        v2_q <= s1_valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_ready_o) begin
      s2_q.clock_pin   <= s1_i.clock_pin;
      s2_q.sample_done <= s1_i.sample_done;
      s2_q.data_ready  <= s1_i.data_ready;
      s2_q.raw         <= s1_i.raw;
      s2_q.mag         <= abs_c[lcr_pkg::READ_W-1:0];
    end
    if (v2_q && en3) begin
      s3_q <= s2_q;
      wt_q <= prod_c[lcr_pkg::PROD_W-1:lcr_pkg::SCALE_W];
    end
  end

  assign out_valid_o     = v3_q;
  assign clock_pin_o     = s3_q.clock_pin;
  assign sample_done_o   = s3_q.sample_done;
  assign raw_reading_o   = s3_q.raw;
  assign net_magnitude_o = s3_q.mag;
  assign weight_o        = wt_q;
  assign data_ready_o    = s3_q.data_ready;

  `ASSERT_PROP(a_s2_held, (v2_q && v3_q && !out_ready_i) |=> v2_q, "stage two request lost on stall")

endmodule

>>> sv/load_cell_adc_serial_reader_top.sv
// Serial readout for a 24-bit two-wire load-cell converter. Every input request
// is one tick of the bit-banged interface: the sampled data-pin level plus a
// command (tick, tare, load preset offset, power down, start), and every request
// yields exactly one result carrying the clock level to drive for that tick, a
// flag on the tick a reading completes, the last reading, its offset-corrected
// magnitude and a Q16-scaled weight. A new request is accepted every cycle
// unless back-pressure on the result channel has filled the pipeline. The path
// has three register stages (engine state and difference, magnitude, and the
// 24 by 16 bit weight multiplier); the first loads at the accepting edge and the
// last offers the result. Configuration writes take effect at once; the user must
// make them while no request is in flight, which the block does not enforce.
`include "assert_macros.svh"

module load_cell_adc_serial_reader_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [lcr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Tick request channel.
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         op_i,
  input  logic                               data_pin_i,
  // Result channel.
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               clock_pin_o,
  output logic                               sample_done_o,
  output logic signed [lcr_pkg::READ_W-1:0]  raw_reading_o,
  output logic [lcr_pkg::READ_W-1:0]         net_magnitude_o,
  output logic [lcr_pkg::READ_W-1:0]         weight_o,
  output logic                               data_ready_o
);

  lcr_pkg::cfg_t cfg_q;
  logic          s1_valid;
  logic          s1_ready;
  lcr_pkg::s1_t  s1;

  // Configuration registers. Writes to an index past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_pulses   <= lcr_pkg::GAIN_W'(1);
      cfg_q.offset_preset <= '0;
      cfg_q.scale_recip   <= lcr_pkg::SCALE_W'(256);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lcr_pkg::CFG_GAIN: begin
          cfg_q.gain_pulses <= cfg_data_i[lcr_pkg::GAIN_W-1:0];
        end
        lcr_pkg::CFG_OFFSET: begin
          cfg_q.offset_preset <= cfg_data_i[lcr_pkg::READ_W-1:0];
        end
        lcr_pkg::CFG_SCALE: begin
          cfg_q.scale_recip <= cfg_data_i[lcr_pkg::SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The engine applies the command, advances the pulse sequencer and forms
  // the new reading and its difference from the offset.
  lcr_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .data_pin_i (data_pin_i),
    .s1_valid_o (s1_valid),
    .s1_ready_i (s1_ready),
    .s1_o       (s1)
  );

  // The scaling pipeline takes the magnitude and then the weight; its last
  // stage is the output register, so a waiting result never blocks new ticks
  // until the whole pipeline is full.
  lcr_scale u_scale (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .scale_i         (cfg_q.scale_recip),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_i            (s1),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .clock_pin_o     (clock_pin_o),
    .sample_done_o   (sample_done_o),
    .raw_reading_o   (raw_reading_o),
    .net_magnitude_o (net_magnitude_o),
    .weight_o        (weight_o),
    .data_ready_o    (data_ready_o)
  );

  // A completed reading always lands on a low clock half of the tick.
  `ASSERT_NEVER(a_done_clk_low, out_valid_o && sample_done_o && clock_pin_o, "done on high clock")

endmodule
